// ----- hdl/stable_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// stable_priority_queue_defines.svh
// Assertion macros shared by the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a trigger implies a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg)
`define SPQ_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned PRI_W     = 8;
  localparam int unsigned OCC_W     = 5;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        prio;
  } entry_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic push;      // insert the incoming entry this cycle
    logic pop;       // remove the front entry this cycle
    logic occ;       // this cell holds a live entry
    logic ins_left;  // the left neighbor shifts right on a push
  } cell_ctrl_t;

endpackage

// ----- hdl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue held sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// in_      in   tuser: command; tdata: value, priority_req
// out_     out  tuser: status; tdata: popped_value, popped_priority, occupancy
//
// One item per cycle while in_tready is high: every cell compares its
// priority with the incoming one in parallel and shifts in the same cycle;
// the result sits in an output register from the cycle after acceptance.
// in_tready falls only while a result waits and out_tready is low. Reset
// clears the entry count and output valid; cell contents need no reset.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [39:32] priority_req
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] popped_value, [39:32] popped_priority,
                                  // [44:40] occupancy, [47:45] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             out_valid_r;
  spq_pkg::status_t out_status_r;
  spq_pkg::entry_t  out_entry_r;
  logic [CNT_W-1:0] out_count_r;

  spq_pkg::entry_t    new_entry;
  spq_pkg::cmd_t      cmd;
  spq_pkg::entry_t    cell_data [DEPTH];
  logic [DEPTH-1:0]   cell_ins;
  logic               accept;
  logic               full;
  logic               empty;
  logic               push_ok;
  logic               pop_ok;
  spq_pkg::status_t   status;

  assign new_entry.value = signed'(in_tdata[31:0]);
  assign new_entry.prio  = in_tdata[39:32];
  assign cmd             = spq_pkg::cmd_t'(in_tuser[0]);

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    status  = spq_pkg::ST_DONE;
    case (cmd)
      spq_pkg::CMD_PUSH: begin
        if (full) status = spq_pkg::ST_FULL;
        else      push_ok = accept;
      end
      spq_pkg::CMD_POP: begin
        if (empty) status = spq_pkg::ST_EMPTY;
        else       pop_ok = accept;
      end
      default: status = spq_pkg::ST_DONE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok)     count_nxt = count_r + CNT_W'(1);
    else if (pop_ok) count_nxt = count_r - CNT_W'(1);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     left_d;
    spq_pkg::entry_t     right_d;

    assign ctrl.push = push_ok;
    assign ctrl.pop  = pop_ok;
    assign ctrl.occ  = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign ctrl.ins_left = 1'b0;
      assign left_d        = new_entry;
    end else begin : g_body
      assign ctrl.ins_left = cell_ins[i-1];
      assign left_d        = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // Slot beyond the end is never live after a pop
      assign right_d = new_entry;
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_i  (left_d),
      .right_i (right_d),
      .new_i   (new_entry),
      .data_o  (cell_data[i]),
      .ins_o   (cell_ins[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: front entry on a good pop, zeros otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_count_r  <= count_nxt;
      out_entry_r  <= pop_ok ? cell_data[0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, spq_pkg::OCC_W'(out_count_r),
                       out_entry_r.prio, out_entry_r.value};

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `SPQ_ASSERT_NEXT(a_full_hold, accept && cmd == spq_pkg::CMD_PUSH && full, $stable(count_r), "refused push changed count")
  `SPQ_ASSERT_ALWAYS(a_front_sorted, count_r < CNT_W'(2) || cell_data[0].prio <= cell_data[1].prio, "front entries out of order")
  `SPQ_ASSERT_ALWAYS(a_empty_status, !out_valid_r || out_status_r != spq_pkg::ST_EMPTY || out_count_r == '0, "empty pop with nonzero occupancy")

endmodule

// ----- hdl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts left or right.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  input  spq_pkg::entry_t     new_i,
  output spq_pkg::entry_t     data_o,
  output logic                ins_o
);

  spq_pkg::entry_t data_r;
  spq_pkg::entry_t data_nxt;

  // New entry lands at or before this slot: slot empty, or strictly
  // lower priority stored here (equal priorities keep the older first).
  assign ins_o  = !ctrl.occ || (data_r.prio > new_i.prio);
  assign data_o = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      if (ctrl.ins_left) begin
        data_nxt = left_i;
      end else if (ins_o) begin
        data_nxt = new_i;
      end
    end else if (ctrl.pop) begin
      data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
